@@ design/tpw_pkg.sv @@
// ----------------------------------------------------------------------------
// tpw_pkg
// Shared constants, codes and controller/datapath interface types of the
// tolerance point weld table.
// ----------------------------------------------------------------------------
package tpw_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int COORD_BITS_DEF = 24;

    localparam int SLOT_W = 10;
    localparam int OP_W   = 2;
    localparam int TOL_W  = 50;
    localparam int SIZE_W = 11;
    localparam int CFG_W  = 50;
    localparam int CFG_IDX_W = 1;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 50'd17;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_TOL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'd1;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    typedef struct packed {
        logic load;
        logic start_walk;
        logic issue;
        logic clear_wr;
        logic finish;
    } tpw_cmd_t;

    typedef struct packed {
        logic bad;
        logic walk_done;
        logic pipe_empty;
        logic found;
        logic clear_last;
        logic out_busy;
    } tpw_stat_t;

endpackage

@@ design/tpw_ram.sv @@
// ----------------------------------------------------------------------------
// tpw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tpw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpw_ctrl
// Sequencer: clearing pass, decode, table walk and result hand-off.
// ----------------------------------------------------------------------------
module tpw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               m_tready,
    input  tpw_pkg::tpw_stat_t stat,
    output tpw_pkg::tpw_cmd_t  cmd
);
    import tpw_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DECODE = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.bad)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.start_walk = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.found || (stat.walk_done && stat.pipe_empty))
                begin
                    state_next = ST_FINISH;
                end
                else if (!stat.walk_done)
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_busy || m_tready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ design/tpw_datapath.sv @@
// ----------------------------------------------------------------------------
// tpw_datapath
// Config registers, map and point memories, distance pipeline,
// result capture and output register.
// ----------------------------------------------------------------------------
module tpw_datapath #(
    parameter int CAPACITY   = tpw_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = tpw_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tpw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpw_pkg::CFG_W-1:0]       cfg_data,
    input  logic [tpw_pkg::OP_W-1:0]        in_op,
    input  logic [tpw_pkg::SLOT_W-1:0]      in_slot,
    input  logic [3*COORD_BITS-1:0]         in_pt,
    input  logic                            m_tready,
    output logic                            out_valid,
    output logic [tpw_pkg::SLOT_W-1:0]      out_canon,
    output logic                            out_merged,
    output logic [3*COORD_BITS-1:0]         out_pt,
    output logic                            out_status,
    input  tpw_pkg::tpw_cmd_t               cmd,
    output tpw_pkg::tpw_stat_t              stat
);
    import tpw_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = IDX_W + 1;
    localparam int C     = COORD_BITS;
    localparam int PT_W  = 3 * C;
    localparam int SQ_W  = 2 * C + 1;
    localparam int SUM_W = SQ_W + 2;

    // configuration
    logic [TOL_W-1:0]  tol_reg;
    logic [SIZE_W-1:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= TOL_RESET;
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOL:  tol_reg  <= cfg_data[TOL_W-1:0];
                REG_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                default:  ;
            endcase
        end
    end

    // request
    logic [OP_W-1:0]   op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [PT_W-1:0]   pt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            slot_reg <= in_slot;
            pt_reg   <= in_pt;
        end
    end

    logic [CNT_W-1:0] lim;
    logic             oor;
    logic [IDX_W-1:0] slot_idx;

    assign lim = (32'(size_reg) >= 32'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(size_reg);
    assign oor = 32'(slot_reg) >= 32'(lim);
    assign slot_idx = IDX_W'(slot_reg);

    assign stat.bad = !(op_reg == OP_INSERT || op_reg == OP_LOOKUP || op_reg == OP_FIND)
                      || ((op_reg == OP_INSERT || op_reg == OP_LOOKUP) && oor);

    // walk counter, also the clearing sweep address
    logic [CNT_W-1:0] cnt_reg, end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= '0;
        end
        else if (cmd.start_walk)
        begin
            cnt_reg <= (op_reg == OP_LOOKUP) ? CNT_W'(slot_reg) : '0;
            unique case (op_reg)
                OP_INSERT: end_reg <= CNT_W'(slot_reg);
                OP_LOOKUP: end_reg <= CNT_W'(slot_reg) + CNT_W'(1);
                default:   end_reg <= lim;
            endcase
        end
        else if (cmd.issue || cmd.clear_wr)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign stat.walk_done  = cnt_reg >= end_reg;
    assign stat.clear_last = cnt_reg == CNT_W'(CAPACITY - 1);

    // memories
    logic             map_we;
    logic [IDX_W-1:0] map_waddr;
    logic [IDX_W:0]   map_wdata, map_rdata;
    logic             pt_we;
    logic [PT_W-1:0]  pt_rdata;
    logic [IDX_W-1:0] map_j;

    logic             found_reg;
    logic [IDX_W-1:0] found_j_reg;
    logic [PT_W-1:0]  found_pt_reg;

    assign map_j     = map_rdata[IDX_W-1:0];
    assign map_we    = cmd.clear_wr || (cmd.finish && !stat.bad && op_reg == OP_INSERT);
    assign map_waddr = cmd.clear_wr ? cnt_reg[IDX_W-1:0] : slot_idx;
    assign map_wdata = cmd.clear_wr ? '0 : {1'b1, found_reg ? found_j_reg : slot_idx};
    assign pt_we     = cmd.finish && !stat.bad && op_reg == OP_INSERT && !found_reg;

    tpw_ram #(.WIDTH(IDX_W + 1), .DEPTH(CAPACITY)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (map_rdata)
    );

    tpw_ram #(.WIDTH(PT_W), .DEPTH(CAPACITY)) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (slot_idx),
        .wdata (pt_reg),
        .raddr (map_j),
        .rdata (pt_rdata)
    );

    // distance pipeline
    logic             v1_reg, v2_reg, v3_reg;
    logic             cand2_reg, cand3_reg;
    logic [IDX_W-1:0] i1_reg, j2_reg, j3_reg;
    logic [PT_W-1:0]  pt3_reg;
    logic [SQ_W-1:0]  sq_reg [3];
    logic             cand1;
    logic [SQ_W-1:0]  sq_next [3];
    logic [SUM_W-1:0] dist_sum;
    logic             hit3;

    assign cand1 = map_rdata[IDX_W] && ((op_reg == OP_FIND) ? (map_j == i1_reg) : 1'b1);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic signed [C:0]     d;
            logic signed [2*C+1:0] p;
            d = $signed({pt_reg[c*C + C - 1], pt_reg[c*C +: C]})
                - $signed({pt_rdata[c*C + C - 1], pt_rdata[c*C +: C]});
            p = d * d;
            sq_next[c] = SQ_W'(p);
        end
    end

    assign dist_sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    assign hit3 = v3_reg && cand3_reg
                  && (op_reg == OP_LOOKUP || 64'(dist_sum) < 64'(tol_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.start_walk)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (hit3)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg    <= cnt_reg[IDX_W-1:0];
        cand2_reg <= cand1;
        j2_reg    <= map_j;
        cand3_reg <= cand2_reg;
        j3_reg    <= j2_reg;
        pt3_reg   <= pt_rdata;
        for (int c = 0; c < 3; c++)
        begin
            sq_reg[c] <= sq_next[c];
        end
        if (hit3 && !found_reg)
        begin
            found_j_reg  <= j3_reg;
            found_pt_reg <= pt3_reg;
        end
    end

    assign stat.pipe_empty = !(v1_reg || v2_reg || v3_reg);
    assign stat.found      = found_reg;

    // output register
    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       canon_reg, canon_next;
    logic                    merged_reg, merged_next;
    logic [PT_W-1:0]         opt_reg, opt_next;
    logic                    status_reg, status_next;

    always_comb
    begin
        canon_next  = '0;
        merged_next = 1'b0;
        opt_next    = '0;
        status_next = 1'b0;
        if (stat.bad)
        begin
            status_next = 1'b1;
        end
        else if (found_reg)
        begin
            canon_next  = SLOT_W'(found_j_reg);
            merged_next = (op_reg != OP_LOOKUP);
            opt_next    = found_pt_reg;
        end
        else
        begin
            unique case (op_reg)
                OP_INSERT:
                begin
                    canon_next = slot_reg;
                    opt_next   = pt_reg;
                end
                OP_FIND:
                begin
                    opt_next = pt_reg;
                end
                default:
                begin
                    status_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            canon_reg  <= canon_next;
            merged_reg <= merged_next;
            opt_reg    <= opt_next;
            status_reg <= status_next;
        end
    end

    assign stat.out_busy = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_canon     = canon_reg;
    assign out_merged    = merged_reg;
    assign out_pt        = opt_reg;
    assign out_status    = status_reg;

endmodule

@@ design/tolerance_point_weld_table_unit.sv @@
// ----------------------------------------------------------------------------
// tolerance_point_weld_table_unit
// Table of 3D Q12.12 points that welds points closer than a tolerance.
//
// Input stream s_*: one beat per request, opcode on s_tuser (insert, lookup,
// find). Output stream m_*: one result beat per request, status on m_tuser.
// Config port cfg_*: register 0 tolerance_squared, 1 size_in_use; write only
// while idle.
// After reset a clearing pass over all CAPACITY entries (1024 by default)
// marks them empty; s_tready stays low during it.
// Insert and find walk the table one entry per cycle, up to size_in_use
// entries, through a read/square/sum pipeline; the walk stops at the first
// match. One request is processed at a time. The result waits in an
// output register while m_tready is low; the next request is taken
// meanwhile and its walk runs, holding only its own result until the
// register frees.
// ----------------------------------------------------------------------------
module tolerance_point_weld_table_unit #(
    parameter int CAPACITY   = tpw_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = tpw_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tpw_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tpw_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // slot_index, coord_x, coord_y, coord_z
    input  logic [((10 + 3*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  logic [tpw_pkg::OP_W-1:0]               s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // canonical_index, merged, out_x, out_y, out_z
    output logic [((11 + 3*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    output logic                                   m_tuser
);
    import tpw_pkg::*;

    localparam int PT_W   = 3 * COORD_BITS;
    localparam int IN_TW  = ((10 + PT_W + 7) / 8) * 8;
    localparam int OUT_TW = ((11 + PT_W + 7) / 8) * 8;

    tpw_cmd_t  cmd;
    tpw_stat_t stat;

    logic [SLOT_W-1:0] out_canon;
    logic              out_merged;
    logic [PT_W-1:0]   out_pt;

    tpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpw_datapath #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_op      (s_tuser),
        .in_slot    (s_tdata[SLOT_W-1:0]),
        .in_pt      (s_tdata[SLOT_W +: PT_W]),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_canon  (out_canon),
        .out_merged (out_merged),
        .out_pt     (out_pt),
        .out_status (m_tuser),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign m_tdata = OUT_TW'({out_pt, out_merged, out_canon});

    logic unused_in;
    assign unused_in = ^s_tdata[IN_TW-1:SLOT_W+PT_W];

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tolerance point weld table. Requests stream in
// bursts, results drain against a stalling sink, and a scoreboard that keeps
// its own copy of the table predicts every result beat.
// ----------------------------------------------------------------------------
class weld_scoreboard;
    logic [23:0] pts [0:1023][0:2];
    logic [9:0]  canon_of [0:1023];
    bit          written [0:1023];
    logic [49:0] tol_sq;
    logic [10:0] size_lim;
    logic [83:0] pending [$];
    int          errors;

    function void clear();
        foreach (written[i]) written[i] = 0;
        tol_sq = tpw_pkg::TOL_RESET;
        size_lim = tpw_pkg::SIZE_RESET;
        errors = 0;
    endfunction

    function void set_reg(logic idx, logic [49:0] v);
        if (idx == tpw_pkg::REG_TOL) tol_sq = v;
        else size_lim = v[10:0];
    endfunction

    function logic [63:0] dist_sq(logic [23:0] a [0:2], logic [23:0] b [0:2]);
        logic [64:0] sum;
        longint d;
        sum = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = longint'($signed(a[c])) - longint'($signed(b[c]));
            if (d < 0) d = -d;
            sum = sum + 65'(d * d);
            if (sum[64]) sum = {1'b0, {64{1'b1}}};
        end
        return sum[63:0];
    endfunction

    function void push(logic [9:0] ci, logic mg, logic [23:0] p [0:2], logic st);
        pending.push_back({st, p[2], p[1], p[0], mg, ci});
    endfunction

    function void note_request(logic [1:0] op, logic [9:0] slot, logic [23:0] p [0:2]);
        logic [23:0] z [0:2];
        int lim;
        logic [9:0] j;
        z = '{24'd0, 24'd0, 24'd0};
        lim = (size_lim < 1024) ? size_lim : 1024;
        if (op == tpw_pkg::OP_INSERT)
        begin
            if (slot >= lim)
            begin
                push(0, 0, z, 1);
                return;
            end
            for (int i = 0; i < slot; i++)
            begin
                if (!written[i]) continue;
                j = canon_of[i];
                if (dist_sq(p, pts[j]) < {14'd0, tol_sq})
                begin
                    canon_of[slot] = j;
                    written[slot] = 1;
                    push(j, 1, pts[j], 0);
                    return;
                end
            end
            pts[slot] = p;
            canon_of[slot] = slot;
            written[slot] = 1;
            push(slot, 0, p, 0);
        end
        else if (op == tpw_pkg::OP_LOOKUP)
        begin
            if (slot >= lim || !written[slot]) push(0, 0, z, 1);
            else push(canon_of[slot], 0, pts[canon_of[slot]], 0);
        end
        else if (op == tpw_pkg::OP_FIND)
        begin
            for (int i = 0; i < lim; i++)
            begin
                if (!written[i] || canon_of[i] != i) continue;
                if (dist_sq(p, pts[i]) < {14'd0, tol_sq})
                begin
                    push(i, 1, pts[i], 0);
                    return;
                end
            end
            push(0, 0, p, 0);
        end
        else push(0, 0, z, 1);
    endfunction

    function void check_result(logic [87:0] d, logic st);
        logic [83:0] e;
        if (pending.size() == 0)
        begin
            $error("unexpected result beat %h", d);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[9:0] !== e[9:0])
        begin
            $error("canonical_index exp %0d got %0d", e[9:0], d[9:0]); errors++;
        end
        if (d[10] !== e[10])
        begin
            $error("merged exp %0d got %0d", e[10], d[10]); errors++;
        end
        if (d[34:11] !== e[34:11])
        begin
            $error("out_x exp %h got %h", e[34:11], d[34:11]); errors++;
        end
        if (d[58:35] !== e[58:35])
        begin
            $error("out_y exp %h got %h", e[58:35], d[58:35]); errors++;
        end
        if (d[82:59] !== e[82:59])
        begin
            $error("out_z exp %h got %h", e[82:59], d[82:59]); errors++;
        end
        if (st !== e[83])
        begin
            $error("status exp %0d got %0d", e[83], st); errors++;
        end
    endfunction
endclass

module tb_top;
    import tpw_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic        m_tuser;

    weld_scoreboard board;
    int n_sent = 0;
    int n_recv = 0;
    bit sink_run = 0;
    int stall_mode = 0;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    tolerance_point_weld_table_unit u_top (.*);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_result(m_tdata, m_tuser);
            n_recv++;
        end

    // sink stall pattern: phases of always-ready, random, and long stalls
    always @(posedge clk)
        if (!sink_run) m_tready <= 1'b0;
        else case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 19) == 0);
        endcase

    always @(posedge clk)
        if (($urandom_range(0, 199)) == 0) stall_mode <= $urandom_range(0, 2);

    task automatic send(logic [1:0] op, logic [9:0] slot, logic [23:0] p [0:2]);
        s_tdata <= {14'd0, p[2], p[1], p[0], slot};
        s_tuser <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_request(op, slot, p);
        n_sent++;
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [49:0] v);
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (1100) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, v);
    endtask

    function automatic logic [23:0] rnd_coord(int near);
        if (near) return 24'($urandom_range(0, 7)) - 24'd3;
        return 24'($urandom);
    endfunction

    task automatic random_phase(int count, int max_slot, int near);
        logic [23:0] p [0:2];
        logic [1:0] op;
        int left;
        left = count;
        while (left > 0)
        begin
            for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--)
            begin
                for (int c = 0; c < 3; c++) p[c] = rnd_coord(near);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: op = OP_INSERT;
                    5, 6: op = OP_LOOKUP;
                    7, 8: op = OP_FIND;
                    default: op = 2'd3;
                endcase
                send(op, 10'($urandom_range(0, max_slot)), p);
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [23:0] p [0:2];
        board = new();
        board.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        sink_run = 1;

        // directed: extremes, every opcode, out of range, unwritten lookup
        p = '{24'h7fffff, 24'h800000, 24'h000000};
        send(OP_INSERT, 10'd0, p);
        p = '{24'h800000, 24'h7fffff, 24'hffffff};
        send(OP_INSERT, 10'd1, p);
        p = '{24'h7fffff, 24'h800000, 24'h000001};
        send(OP_INSERT, 10'd5, p);
        send(OP_LOOKUP, 10'd5, p);
        send(OP_LOOKUP, 10'd3, p);
        send(OP_LOOKUP, 10'd1023, p);
        send(OP_FIND, 10'd1023, p);
        p = '{24'h123456, 24'h654321, 24'h0f0f0f};
        send(OP_FIND, 10'd0, p);
        send(2'd3, 10'h3ff, p);
        send(OP_INSERT, 10'd1023, p);
        write_reg(REG_SIZE, 50'd8);
        send(OP_INSERT, 10'd8, p);
        send(OP_LOOKUP, 10'd8, p);
        send(OP_INSERT, 10'd7, p);
        write_reg(REG_TOL, 50'd0);
        send(OP_INSERT, 10'd6, p);
        write_reg(REG_TOL, {50{1'b1}});
        send(OP_INSERT, 10'd4, p);
        send(OP_FIND, 10'd2, p);
        write_reg(REG_SIZE, 50'd0);
        send(OP_LOOKUP, 10'd0, p);
        write_reg(REG_SIZE, 50'd2047);
        send(OP_LOOKUP, 10'd5, p);
        s_tvalid <= 1'b0;

        write_reg(REG_TOL, 50'd17);
        write_reg(REG_SIZE, 50'd32);
        random_phase(200, 40, 1);
        write_reg(REG_TOL, 50'd40000);
        write_reg(REG_SIZE, 50'd64);
        random_phase(160, 70, 1);
        write_reg(REG_TOL, {50{1'b1}});
        write_reg(REG_SIZE, 50'd16);
        random_phase(80, 20, 0);
        write_reg(REG_TOL, 50'($urandom));
        write_reg(REG_SIZE, 50'd1024);
        random_phase(100, 1023, 0);
        write_reg(REG_SIZE, 50'd1);
        random_phase(40, 3, 1);

        while (board.pending.size() != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
        $display("covered %0d requests, %0d results over 5 size/tolerance settings",
                 n_sent, n_recv);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
